// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AST_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/lcls_pkg.sv
// ----------------------------------------------------------------------------
// LED cube layer scan package
// Cube geometry, field widths and pulse codes for the layer scan serializer.
// ----------------------------------------------------------------------------
package lcls_pkg;

    localparam int SIDE    = 5;
    localparam int NVOX    = SIDE * SIDE;
    localparam int EN_W    = 5;
    localparam int LAYER_W = 3;
    localparam int RC_W    = $clog2(SIDE);
    localparam int IDX_W   = $clog2(NVOX);

    typedef enum logic [1:0] {
        PK_RESET = 2'd0,
        PK_SHIFT = 2'd1,
        PK_STORE = 2'd2
    } t_pulse_kind;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RESET,
        PH_SHIFT,
        PH_STORE
    } t_phase;

endpackage

// File: hw/rtl/led_cube_layer_scan_serializer_top.sv
// ----------------------------------------------------------------------------
// LED cube layer scan serializer
// Turns one layer or power toggle beat into a train of pulse beats.
// ----------------------------------------------------------------------------
// A show beat for a valid layer while the cube is powered produces 26 result
// beats, one per cycle when the output is not stalled: a reset pulse, 24 shift
// pulses (column outer, row inner, both descending, corner voxel withheld) and
// a store pulse carrying the corner voxel on the special line. A power toggle
// produces a reset and a store (2 beats) and then flips power. A show beat
// while powered off or with a layer index of SIDE or more produces nothing.
// The single scan sequencer, which emits one pulse per cycle, sets the rate;
// the next input beat is taken in the cycle its predecessor emits its last
// pulse. While a result waits stalled in the output register, the sequencer
// holds its place until it is taken.
module led_cube_layer_scan_serializer_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_command,
    input  logic [lcls_pkg::LAYER_W-1:0] i_layer,
    input  logic [lcls_pkg::NVOX-1:0]   i_layer_bits,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_pulse_kind,
    output logic                        o_data_bit,
    output logic                        o_special_bit,
    output logic [lcls_pkg::EN_W-1:0]   o_layers_at_latch,
    output logic [lcls_pkg::EN_W-1:0]   o_layers_after,
    output logic                        o_last
);
    import lcls_pkg::*;

    // Working slot
    t_phase                r_phase, n_phase;
    logic                  r_cmd;
    logic [LAYER_W-1:0]    r_layer;
    logic [NVOX-1:0]       r_bits;
    logic [RC_W-1:0]       r_row, n_row;
    logic [RC_W-1:0]       r_col, n_col;

    // Architectural state
    logic                  r_power, n_power;
    logic [EN_W-1:0]       r_en, n_en;

    // Output register
    logic                  r_ov, n_ov;
    t_pulse_kind           r_kind, n_kind;
    logic                  r_data, n_data;
    logic                  r_special, n_special;
    logic [EN_W-1:0]       r_latch, n_latch;
    logic [EN_W-1:0]       r_after, n_after;
    logic                  r_last, n_last;

    logic                  w_out_adv;
    logic                  w_drop;
    logic                  w_emit;
    logic                  w_finish;
    logic                  w_in_acc;
    logic [IDX_W-1:0]      w_idx;
    logic [LAYER_W-1:0]    w_prev;
    logic [EN_W-1:0]       w_clr;
    logic [EN_W-1:0]       w_set;
    logic                  w_beat_quiet;
    logic                  w_scan_tail;

    assign w_out_adv = !r_ov || !i_out_stall;
    assign w_drop    = (r_phase == PH_RESET) && !r_cmd
                       && (!r_power || (r_layer >= LAYER_W'(SIDE)));
    assign w_emit    = (r_phase != PH_IDLE) && !w_drop && w_out_adv;
    assign w_finish  = w_drop || (w_emit && (r_phase == PH_STORE));
    assign o_in_stall = (r_phase != PH_IDLE) && !w_finish;
    assign w_in_acc  = i_in_valid && !o_in_stall;

    assign w_idx  = IDX_W'(r_row) * IDX_W'(SIDE) + IDX_W'(r_col);
    assign w_prev = (r_layer == '0) ? LAYER_W'(SIDE - 1) : r_layer - LAYER_W'(1);
    assign w_clr  = r_en & ~(EN_W'(1) << w_prev);
    assign w_set  = w_clr | (EN_W'(1) << r_layer);

    // Next state of the sequencer
    always_comb begin
        n_phase = r_phase;
        n_row   = r_row;
        n_col   = r_col;
        if (w_in_acc) begin
            n_phase = PH_RESET;
        end else if (w_finish) begin
            n_phase = PH_IDLE;
        end else if (w_emit) begin
            case (r_phase)
                PH_RESET: begin
                    n_phase = r_cmd ? PH_STORE : PH_SHIFT;
                    // The corner voxel is skipped, so the scan starts one row down.
                    n_row   = RC_W'(SIDE - 2);
                    n_col   = RC_W'(SIDE - 1);
                end
                PH_SHIFT: begin
                    if (r_row == '0) begin
                        n_row = RC_W'(SIDE - 1);
                        n_col = r_col - RC_W'(1);
                        if (r_col == '0) begin
                            n_phase = PH_STORE;
                        end
                    end else begin
                        n_row = r_row - RC_W'(1);
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Result beat and architectural state updates
    always_comb begin
        n_ov      = r_ov && i_out_stall;
        n_kind    = r_kind;
        n_data    = r_data;
        n_special = r_special;
        n_latch   = r_latch;
        n_after   = r_after;
        n_last    = r_last;
        n_power   = r_power;
        n_en      = r_en;
        if (w_emit) begin
            n_ov      = 1'b1;
            n_data    = 1'b0;
            n_special = 1'b0;
            n_latch   = r_en;
            n_after   = r_en;
            n_last    = 1'b0;
            case (r_phase)
                PH_RESET: begin
                    n_kind = PK_RESET;
                end
                PH_SHIFT: begin
                    n_kind = PK_SHIFT;
                    n_data = r_bits[w_idx];
                end
                PH_STORE: begin
                    n_kind = PK_STORE;
                    n_last = 1'b1;
                    if (r_cmd) begin
                        n_power = !r_power;
                    end else begin
                        n_special = r_bits[NVOX-1];
                        n_latch   = w_clr;
                        n_after   = w_set;
                        n_en      = w_set;
                    end
                end
                default: begin
                    n_kind = r_kind;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_power <= 1'b1;
            r_en    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_power <= n_power;
            r_en    <= n_en;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd   <= i_command;
            r_layer <= i_layer;
            r_bits  <= i_layer_bits;
        end
        r_row     <= n_row;
        r_col     <= n_col;
        r_kind    <= n_kind;
        r_data    <= n_data;
        r_special <= n_special;
        r_latch   <= n_latch;
        r_after   <= n_after;
        r_last    <= n_last;
    end

    assign o_out_valid       = r_ov;
    assign o_pulse_kind      = r_kind;
    assign o_data_bit        = r_data;
    assign o_special_bit     = r_special;
    assign o_layers_at_latch = r_latch;
    assign o_layers_after    = r_after;
    assign o_last            = r_last;

    assign w_beat_quiet = !r_last && !r_special && (r_latch == r_after);
    assign w_scan_tail  = (r_phase == PH_SHIFT) || (r_phase == PH_STORE);

`include "assert_macros.svh"

    `AST_SAME(a_store_is_last, i_clk, i_rst_n, r_ov && (r_kind == PK_STORE), r_last)
    `AST_SAME(a_non_store_quiet, i_clk, i_rst_n, r_ov && (r_kind != PK_STORE), w_beat_quiet)
    `AST_NEXT(a_shift_to_shift_or_store, i_clk, i_rst_n, r_phase == PH_SHIFT, w_scan_tail)

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED cube layer scan serializer testbench
// Drives show and power toggle beats through the serializer and predicts the
// reset, shift and store pulse train of every accepted beat.
// ----------------------------------------------------------------------------
module tb;
    import lcls_pkg::*;

    localparam logic CMD_SHOW  = 1'b0;
    localparam logic CMD_POWER = 1'b1;
    localparam int   CORNER    = (SIDE - 1) * SIDE + (SIDE - 1);

    typedef struct {
        t_pulse_kind       kind;
        logic              data_bit;
        logic              special_bit;
        logic [EN_W-1:0]   at_latch;
        logic [EN_W-1:0]   after;
        logic              is_last;
    } t_scan_pulse;

    // Tracks the cube power and the layer enables, and keeps the pulses that
    // are still owed in arrival order.
    class layer_scan_board;
        bit                powered;
        logic [EN_W-1:0]   enables;
        t_scan_pulse       owed_pulses[$];
        int                mismatches;

        function new();
            powered    = 1'b1;
            enables    = '0;
            mismatches = 0;
        endfunction

        function void owe(t_pulse_kind kind, logic data_bit, logic special_bit,
                          logic [EN_W-1:0] at_latch, logic [EN_W-1:0] after,
                          logic is_last);
            t_scan_pulse p;
            p.kind        = kind;
            p.data_bit    = data_bit;
            p.special_bit = special_bit;
            p.at_latch    = at_latch;
            p.after       = after;
            p.is_last     = is_last;
            owed_pulses.insert(owed_pulses.size(), p);
        endfunction

        // Returns the number of pulses the beat is expected to produce.
        function int take_beat(logic command, logic [LAYER_W-1:0] layer,
                               logic [NVOX-1:0] bits);
            int              row;
            int              col;
            int              prev;
            int              count;
            logic            corner_bit;
            logic [EN_W-1:0] cleared;
            count = 0;
            if (command == CMD_POWER) begin
                owe(PK_RESET, 1'b0, 1'b0, enables, enables, 1'b0);
                owe(PK_STORE, 1'b0, 1'b0, enables, enables, 1'b1);
                powered = !powered;
                return 2;
            end
            if (!powered || layer >= SIDE)
                return 0;
            owe(PK_RESET, 1'b0, 1'b0, enables, enables, 1'b0);
            count = 1;
            for (col = SIDE - 1; col >= 0; col--) begin
                for (row = SIDE - 1; row >= 0; row--) begin
                    if (row * SIDE + col != CORNER) begin
                        owe(PK_SHIFT, bits[row * SIDE + col], 1'b0, enables, enables, 1'b0);
                        count++;
                    end
                end
            end
            corner_bit = bits[CORNER];
            // The layer below is switched off before the latch; layer 0 wraps
            // around to the top layer.
            prev    = (layer == 0) ? SIDE - 1 : int'(layer) - 1;
            cleared = enables & ~(EN_W'(1) << prev);
            enables = cleared | (EN_W'(1) << layer);
            owe(PK_STORE, 1'b0, corner_bit, cleared, enables, 1'b1);
            return count + 1;
        endfunction

        function void flag(string field, logic [7:0] want, logic [7:0] got);
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        endfunction

        function void check_pulse(t_scan_pulse got);
            t_scan_pulse want;
            if (owed_pulses.size() == 0) begin
                mismatches++;
                $display("%0t: pulse with none expected, expected none, actual kind %0h",
                         $time, got.kind);
                return;
            end
            want = owed_pulses.pop_front();
            if (got.kind !== want.kind)
                flag("pulse_kind", want.kind, got.kind);
            if (got.data_bit !== want.data_bit)
                flag("data_bit", want.data_bit, got.data_bit);
            if (got.special_bit !== want.special_bit)
                flag("special_bit", want.special_bit, got.special_bit);
            if (got.at_latch !== want.at_latch)
                flag("layers_at_latch", want.at_latch, got.at_latch);
            if (got.after !== want.after)
                flag("layers_after", want.after, got.after);
            if (got.is_last !== want.is_last)
                flag("last", want.is_last, got.is_last);
        endfunction

        function int owed();
            return owed_pulses.size();
        endfunction
    endclass

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_stall;
    logic                i_command    = CMD_SHOW;
    logic [LAYER_W-1:0]  i_layer      = '0;
    logic [NVOX-1:0]     i_layer_bits = '0;
    logic                o_out_valid;
    logic                i_out_stall  = 1'b0;
    logic [1:0]          o_pulse_kind;
    logic                o_data_bit;
    logic                o_special_bit;
    logic [EN_W-1:0]     o_layers_at_latch;
    logic [EN_W-1:0]     o_layers_after;
    logic                o_last;

    layer_scan_board scan = new();
    bit              quiet = 1'b0;

    led_cube_layer_scan_serializer_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_command         (i_command),
        .i_layer           (i_layer),
        .i_layer_bits      (i_layer_bits),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_pulse_kind      (o_pulse_kind),
        .o_data_bit        (o_data_bit),
        .o_special_bit     (o_special_bit),
        .o_layers_at_latch (o_layers_at_latch),
        .o_layers_after    (o_layers_after),
        .o_last            (o_last)
    );

    always #4 i_clk = ~i_clk;

    // Handshake levels only change at the rising edge, so the stall seen at
    // the falling edge is the one the next rising edge acts on.
    task automatic send_beat(input logic command, input logic [LAYER_W-1:0] layer,
                             input logic [NVOX-1:0] bits, output int produced);
        i_in_valid   <= 1'b1;
        i_command    <= command;
        i_layer      <= layer;
        i_layer_bits <= bits;
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
        produced = scan.take_beat(command, layer, bits);
    endtask

    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (scan.owed() != 0) @(posedge i_clk);
    endtask

    task automatic show(input logic command, input logic [LAYER_W-1:0] layer,
                        input logic [NVOX-1:0] bits);
        int produced;
        maybe_gap();
        send_beat(command, layer, bits, produced);
    endtask

    // Result side: checks every accepted beat and stalls in random bursts.
    initial begin : result_side
        t_scan_pulse got;
        int          hold;
        int          run;
        hold = 0;
        run  = 0;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.kind        = t_pulse_kind'(o_pulse_kind);
                got.data_bit    = o_data_bit;
                got.special_bit = o_special_bit;
                got.at_latch    = o_layers_at_latch;
                got.after       = o_layers_after;
                got.is_last     = o_last;
                scan.check_pulse(got);
            end
            @(posedge i_clk);
            if (quiet) begin
                i_out_stall <= 1'b0;
            end else if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else if (run > 0) begin
                run--;
                i_out_stall <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                hold = $urandom_range(1, 8) - 1;
                i_out_stall <= 1'b1;
            end else begin
                run = $urandom_range(1, 40);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        int                 shown;
        int                 produced;
        int                 pick;
        logic [LAYER_W-1:0] layer;
        logic [NVOX-1:0]    bits;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        show(CMD_SHOW, 3'd0, '1);
        show(CMD_SHOW, 3'd1, '0);
        show(CMD_SHOW, 3'd2, 25'h1555555);
        show(CMD_SHOW, 3'd3, 25'h0AAAAAA);
        show(CMD_SHOW, 3'd4, 25'h1000000);
        show(CMD_SHOW, 3'd4, 25'h0FFFFFF);
        show(CMD_SHOW, 3'd0, 25'h0000001);
        show(CMD_SHOW, 3'd5, '1);
        show(CMD_SHOW, 3'd6, 25'h1555555);
        show(CMD_SHOW, 3'd7, '1);
        show(CMD_POWER, 3'd0, '0);
        show(CMD_SHOW, 3'd2, '1);
        show(CMD_SHOW, 3'd7, '0);
        show(CMD_POWER, 3'd7, '1);
        show(CMD_SHOW, 3'd3, 25'h00F83E0);
        show(CMD_POWER, 3'd4, 25'h1FFFFFF);
        show(CMD_POWER, 3'd1, 25'h0000000);
        show(CMD_SHOW, 3'd1, 25'h000001F);
        show(CMD_SHOW, 3'd2, 25'h1084210);

        // Hold the input back until the whole train so far has come out.
        drain();

        shown = 0;
        while (shown < 145) begin
            if (shown == 72)
                drain();
            quiet = (shown >= 120);
            pick  = $urandom_range(0, 99);
            bits  = NVOX'($urandom);
            if (pick < 10)
                bits = (pick < 5) ? '1 : '0;
            layer = LAYER_W'($urandom_range(0, SIDE - 1));
            maybe_gap();
            if (!scan.powered) begin
                // A show while the cube is off is dropped, so come back on soon.
                if (pick < 50)
                    send_beat(CMD_POWER, LAYER_W'($urandom), bits, produced);
                else
                    send_beat(CMD_SHOW, LAYER_W'($urandom), bits, produced);
            end else if (pick < 6) begin
                send_beat(CMD_POWER, LAYER_W'($urandom), bits, produced);
            end else if (pick < 12) begin
                send_beat(CMD_SHOW, LAYER_W'($urandom_range(SIDE, 7)), bits, produced);
            end else begin
                send_beat(CMD_SHOW, layer, bits, produced);
            end
            if (produced != 0)
                shown++;
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (scan.mismatches == 0 && scan.owed() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
